/* src/kct_pkg.sv */
// Package for the keyed count table: field widths, codes and the record that
// the head update logic hands to the sequencer. No dependencies.
`timescale 1ns / 1ps

package kct_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  // Fixed field widths.
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned COUNT_W  = 24;
  localparam int unsigned USED_W   = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_SUB    = 2'd1,
    ACT_LOOKUP = 2'd2
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  // Outcome of the entry that sits at the head of the ring this cycle.
  typedef struct packed {
    logic                 touch;   // entry found or appended here
    logic                 del;     // found entry must be removed
    status_e              status;
    logic [COUNT_W-1:0]   count;   // count reported for this item
  } head_res_t;

endpackage

/* src/kct_cell.sv */
// One cell of the entry ring: holds one key and its count and loads from its
// upper neighbor on a rotate step, or on compaction at or above the removed slot.
// Depends on kct_pkg.
`timescale 1ns / 1ps

module kct_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 6
) (
  input  logic                        clk_i,
  input  logic                        rotate_i,
  input  logic                        compact_i,
  input  logic [IDX_W-1:0]            del_slot_i,
  input  logic [kct_pkg::KEY_W-1:0]   key_i,
  input  logic [kct_pkg::COUNT_W-1:0] count_i,
  output logic [kct_pkg::KEY_W-1:0]   key_o,
  output logic [kct_pkg::COUNT_W-1:0] count_o
);
  import kct_pkg::*;

  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] count_q;
  logic               load;

  // On compaction every cell at or above the removed slot moves down by one.
  assign load = rotate_i | (compact_i & (del_slot_i <= IDX_W'(CELL_IDX)));

  always_ff @(posedge clk_i) begin
    if (load) begin
      key_q   <= key_i;
      count_q <= count_i;
    end
  end

  assign key_o   = key_q;
  assign count_o = count_q;

endmodule

/* src/kct_head.sv */
// Update logic at the head of the entry ring: matches the key, applies the
// add, subtract or lookup, or appends a new entry. Depends on kct_pkg.
`timescale 1ns / 1ps

module kct_head #(
  parameter int unsigned IDX_W  = 6,
  parameter int unsigned FILL_W = 7
) (
  input  logic [kct_pkg::ACT_W-1:0]   act_i,
  input  logic [kct_pkg::KEY_W-1:0]   req_key_i,
  input  logic [kct_pkg::DELTA_W-1:0] delta_i,
  input  logic [IDX_W-1:0]            step_i,
  input  logic [FILL_W-1:0]           fill_i,
  input  logic                        found_i,
  input  logic [kct_pkg::KEY_W-1:0]   head_key_i,
  input  logic [kct_pkg::COUNT_W-1:0] head_count_i,
  output logic [kct_pkg::KEY_W-1:0]   tail_key_o,
  output logic [kct_pkg::COUNT_W-1:0] tail_count_o,
  output kct_pkg::head_res_t          res_o
);
  import kct_pkg::*;

  logic [FILL_W-1:0]  step_ext;
  logic               hit;
  logic               ins;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat;
  logic [COUNT_W-1:0] delta_ext;
  logic [COUNT_W-1:0] new_count;
  logic               del;

  assign step_ext  = FILL_W'(step_i);
  assign delta_ext = COUNT_W'(delta_i);
  assign hit = !found_i && (step_ext < fill_i) && (head_key_i == req_key_i);
  // The first free place comes right after the last valid entry has passed.
  assign ins = !found_i && (act_e'(act_i) == ACT_ADD) && (step_ext == fill_i);

  assign sum = (COUNT_W + 1)'(head_count_i) + (COUNT_W + 1)'(delta_i);
  assign sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

  always_comb begin
    unique case (act_e'(act_i))
      ACT_ADD: begin
        new_count = sat;
        del       = (sat == '0);
      end
      ACT_SUB: begin
        new_count = head_count_i - delta_ext;
        del       = (delta_ext >= head_count_i);
      end
      default: begin
        new_count = head_count_i;
        del       = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o        = '{touch: hit | ins, del: hit & del, status: ST_UPDATED, count: '0};
    tail_key_o   = head_key_i;
    tail_count_o = head_count_i;
    if (ins) begin
      res_o.status = ST_INSERTED;
      res_o.count  = delta_ext;
      tail_key_o   = req_key_i;
      tail_count_o = delta_ext;
    end else if (hit) begin
      if (del) begin
        res_o.status = ST_DELETED;
      end else begin
        res_o.count  = new_count;
        tail_count_o = new_count;
      end
    end
  end

endmodule

/* src/keyed_count_table.sv */
// Keyed count table: up to TABLE_ENTRIES key/count pairs in insertion order.
// One item is worked on at a time: an accepted item makes one full turn of
// the entry ring past the head update logic, then a finish step, which waits
// while the output register holds a stalled result, before the next is taken.
// Reset clears the fill level and the handshake state; entry contents stay
// undefined and are never read before being written, so no clearing pass.
`timescale 1ns / 1ps

module keyed_count_table #(
  parameter int unsigned TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kct_pkg::ACT_W-1:0]    action_i,
  input  logic [kct_pkg::KEY_W-1:0]    part_key_i,
  input  logic [kct_pkg::DELTA_W-1:0]  delta_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kct_pkg::STATUS_W-1:0] status_o,
  output logic [kct_pkg::SLOT_W-1:0]   slot_o,
  output logic [kct_pkg::COUNT_W-1:0]  count_now_o,
  output logic [kct_pkg::USED_W-1:0]   entries_used_o
);
  import kct_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);

  // The entries form a ring of cells. During a scan every cell hands its
  // entry down by one place each cycle, so the head cell shows entry 0, 1, 2
  // and so on in turn. The head logic rewrites the entry on its way back into
  // the top cell. After TABLE_ENTRIES steps every entry is home again.
  state_e state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  logic              found_q;

  // Request held for the whole scan.
  logic [ACT_W-1:0]   act_q;
  logic [KEY_W-1:0]   key_q;
  logic [DELTA_W-1:0] delta_q;
  logic [IDX_W-1:0]   step_q;

  // Result collected during the scan.
  status_e            res_status_q;
  logic [IDX_W-1:0]   res_slot_q;
  logic [COUNT_W-1:0] res_count_q;
  logic               res_del_q;

  // Output register, so a waiting result does not block the next item.
  status_e            out_status_q;
  logic [IDX_W-1:0]   out_slot_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [FILL_W-1:0]  out_used_q;

  logic in_fire;
  logic rotate;
  logic fin_fire;
  logic compact;

  logic [KEY_W-1:0]   ring_key   [TABLE_ENTRIES];
  logic [COUNT_W-1:0] ring_count [TABLE_ENTRIES];
  logic [KEY_W-1:0]   tail_key;
  logic [COUNT_W-1:0] tail_count;
  head_res_t          head_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    rotate      = 1'b0;
    fin_fire    = 1'b0;
    out_valid_d = out_valid_q;
    fill_d      = fill_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rotate = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Finish only once the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          fin_fire    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (res_status_q == ST_INSERTED) begin
            fill_d = fill_q + FILL_W'(1);
          end else if (res_status_q == ST_DELETED) begin
            fill_d = fill_q - FILL_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A removed entry is closed up in one step: every cell at or above its
  // slot takes the entry of its upper neighbor.
  assign compact = fin_fire && res_del_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        found_q <= 1'b0;
        step_q  <= '0;
      end else if (rotate) begin
        step_q <= step_q + IDX_W'(1);
        if (head_res.touch) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q        <= action_i;
      key_q        <= part_key_i;
      delta_q      <= delta_i;
      // Without a hit or an append, an add means the table was full.
      res_status_q <= (act_e'(action_i) == ACT_ADD) ? ST_FULL : ST_NOT_FOUND;
      res_slot_q   <= '0;
      res_count_q  <= '0;
      res_del_q    <= 1'b0;
    end else if (rotate && head_res.touch) begin
      res_status_q <= head_res.status;
      res_slot_q   <= step_q;
      res_count_q  <= head_res.count;
      res_del_q    <= head_res.del;
    end
    if (fin_fire) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_count_q  <= res_count_q;
      out_used_q   <= fill_d;
    end
  end

  kct_head #(
    .IDX_W  (IDX_W),
    .FILL_W (FILL_W)
  ) u_head (
    .act_i        (act_q),
    .req_key_i    (key_q),
    .delta_i      (delta_q),
    .step_i       (step_q),
    .fill_i       (fill_q),
    .found_i      (found_q),
    .head_key_i   (ring_key[0]),
    .head_count_i (ring_count[0]),
    .tail_key_o   (tail_key),
    .tail_count_o (tail_count),
    .res_o        (head_res)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]   nb_key;
    logic [COUNT_W-1:0] nb_count;

    if (i == TABLE_ENTRIES - 1) begin : g_top
      // The top cell takes the entry that leaves the head logic.
      assign nb_key   = tail_key;
      assign nb_count = tail_count;
    end else begin : g_mid
      assign nb_key   = ring_key[i+1];
      assign nb_count = ring_count[i+1];
    end

    kct_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rotate_i   (rotate),
      .compact_i  (compact),
      .del_slot_i (res_slot_q),
      .key_i      (nb_key),
      .count_i    (nb_count),
      .key_o      (ring_key[i]),
      .count_o    (ring_count[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_o         = SLOT_W'(out_slot_q);
  assign count_now_o    = out_count_q;
  assign entries_used_o = USED_W'(out_used_q);

endmodule

/* src/kct_checker.sv */
// Port-level checks for the keyed count table and the bind that attaches
// them to every instance of the top level. Depends on kct_pkg.
`timescale 1ns / 1ps

module kct_props (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [kct_pkg::STATUS_W-1:0] status_o,
  input logic [kct_pkg::SLOT_W-1:0]   slot_o,
  input logic [kct_pkg::COUNT_W-1:0]  count_now_o,
  input logic [kct_pkg::USED_W-1:0]   entries_used_o
);
  import kct_pkg::*;

  // A result held under stall keeps its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(slot_o)
      && $stable(count_now_o) && $stable(entries_used_o))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken during a scan");

  // An appended entry lands right after the previous last entry.
  a_insert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_INSERTED) |->
      (entries_used_o != '0) && (slot_o == SLOT_W'(entries_used_o - USED_W'(1))))
    else $error("inserted slot does not match fill level");

  // Removed or absent entries report a zero count.
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_DELETED) || (status_o == ST_NOT_FOUND)
      || (status_o == ST_FULL)) |-> (count_now_o == '0))
    else $error("nonzero count on delete or miss");

  // A miss or a full table points at no entry.
  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_NOT_FOUND) || (status_o == ST_FULL))
      |-> (slot_o == '0))
    else $error("slot set on a miss");

endmodule

bind keyed_count_table kct_props u_kct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .slot_o         (slot_o),
  .count_now_o    (count_now_o),
  .entries_used_o (entries_used_o)
);

/* tb/kct_checker.sv */
// Checker for the keyed count table: watches both item channels, keeps a shadow
// copy of the table, predicts every result and compares it field by field.
// Depends on kct_pkg for field widths, the action and status codes.
`timescale 1ns / 1ps

module kct_checker #(
  parameter int unsigned TABLE_ENTRIES = kct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [kct_pkg::ACT_W-1:0]    action_i,
  input  logic [kct_pkg::KEY_W-1:0]    part_key_i,
  input  logic [kct_pkg::DELTA_W-1:0]  delta_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [kct_pkg::STATUS_W-1:0] status_i,
  input  logic [kct_pkg::SLOT_W-1:0]   slot_i,
  input  logic [kct_pkg::COUNT_W-1:0]  count_now_i,
  input  logic [kct_pkg::USED_W-1:0]   entries_used_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  compared_o
);
  import kct_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic [USED_W-1:0]  used;
  } reply_t;

  logic [KEY_W-1:0]   shadow_key   [TABLE_ENTRIES];
  logic [COUNT_W-1:0] shadow_count [TABLE_ENTRIES];
  int unsigned        shadow_fill;
  reply_t             due_replies  [$];

  initial begin
    shadow_fill   = 0;
    mismatches_o  = 0;
    outstanding_o = 0;
    compared_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] mismatch in %s after %0d results: expected %0d, got %0d",
             $time, what, compared_o, want, got);
    mismatches_o++;
  endtask

  // Removes one entry and closes the gap, keeping insertion order.
  function automatic void drop_entry(input int at);
    for (int j = at; j + 1 < int'(shadow_fill); j++) begin
      shadow_key[j]   = shadow_key[j+1];
      shadow_count[j] = shadow_count[j+1];
    end
    shadow_fill--;
  endfunction

  // Applies one request to the shadow table and returns the reply it gives.
  function automatic reply_t apply_table_op(input logic [ACT_W-1:0] act,
                                            input logic [KEY_W-1:0] key,
                                            input logic [DELTA_W-1:0] amt);
    reply_t           r;
    int               hit;
    logic [COUNT_W:0] sum;
    hit      = -1;
    r.status = ST_NOT_FOUND;
    r.slot   = '0;
    r.count  = '0;
    for (int i = 0; i < int'(shadow_fill); i++)
      if (hit < 0 && shadow_key[i] == key) hit = i;

    if (act == ACT_ADD) begin
      if (hit < 0) begin
        if (shadow_fill >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[shadow_fill]   = key;
          shadow_count[shadow_fill] = {{(COUNT_W-DELTA_W){1'b0}}, amt};
          r.slot   = shadow_fill[SLOT_W-1:0];
          r.count  = {{(COUNT_W-DELTA_W){1'b0}}, amt};
          r.status = ST_INSERTED;
          shadow_fill++;
        end
      end else begin
        sum = {1'b0, shadow_count[hit]} + {{(COUNT_W-DELTA_W+1){1'b0}}, amt};
        if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
        r.slot = hit[SLOT_W-1:0];
        // Only a zero count plus a zero amount lands here.
        if (sum == '0) begin
          drop_entry(hit);
          r.status = ST_DELETED;
        end else begin
          shadow_count[hit] = sum[COUNT_W-1:0];
          r.count  = sum[COUNT_W-1:0];
          r.status = ST_UPDATED;
        end
      end
    end else if (act == ACT_SUB) begin
      if (hit >= 0) begin
        r.slot = hit[SLOT_W-1:0];
        if ({{(COUNT_W-DELTA_W){1'b0}}, amt} >= shadow_count[hit]) begin
          drop_entry(hit);
          r.status = ST_DELETED;
        end else begin
          shadow_count[hit] = shadow_count[hit] - {{(COUNT_W-DELTA_W){1'b0}}, amt};
          r.count  = shadow_count[hit];
          r.status = ST_UPDATED;
        end
      end
    end else begin
      // Lookup, and the unused action code behaves the same way.
      if (hit >= 0) begin
        r.slot   = hit[SLOT_W-1:0];
        r.count  = shadow_count[hit];
        r.status = ST_UPDATED;
      end
    end
    r.used = shadow_fill[USED_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (due_replies.size() == 0) begin
          report_mismatch("result with none outstanding", '0, 32'(status_i));
        end else begin
          want = due_replies.pop_front();
          compared_o++;
          if (status_i !== want.status)
            report_mismatch("status", 32'(want.status), 32'(status_i));
          if (slot_i !== want.slot)
            report_mismatch("slot", 32'(want.slot), 32'(slot_i));
          if (count_now_i !== want.count)
            report_mismatch("count_now", 32'(want.count), 32'(count_now_i));
          if (entries_used_i !== want.used)
            report_mismatch("entries_used", 32'(want.used), 32'(entries_used_i));
        end
      end
      if (in_valid_i && !in_stall_i)
        due_replies.push_back(apply_table_op(action_i, part_key_i, delta_i));
      outstanding_o = due_replies.size();
    end
  end

endmodule

/* tb/tb_keyed_count_table.sv */
// Top of the keyed count table testbench: clock, reset, request stimulus,
// result-side stalls, the watchdog and the verdict. Depends on kct_pkg,
// keyed_count_table and kct_checker.
`timescale 1ns / 1ps

module tb_keyed_count_table;
  import kct_pkg::*;

  localparam int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  // The unused action code; the block must treat it as a lookup.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  // Keys drawn from a pool a little larger than the table, so that the table
  // fills up and adds on new keys get turned away.
  localparam int unsigned POOL_KEYS = TABLE_ENTRIES + 8;
  // One key that only ever gets added to, so that its count saturates.
  localparam logic [KEY_W-1:0] HOT_KEY = 32'h1234_5678;
  localparam int unsigned RANDOM_PER_PHASE = 628;
  // A whole item, scan and finish, plus a long receiver stall on top of it,
  // still stays far below this many cycles without any handshake.
  localparam int unsigned QUIET_LIMIT = 40 * (TABLE_ENTRIES + 2);

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action    = '0;
  logic [KEY_W-1:0]    part_key  = '0;
  logic [DELTA_W-1:0]  delta     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  count_now;
  logic [USED_W-1:0]   entries_used;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 76;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;

  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyed_count_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .part_key_i    (part_key),
    .delta_i       (delta),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .slot_o        (slot),
    .count_now_o   (count_now),
    .entries_used_o(entries_used)
  );

  kct_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .action_i      (action),
    .part_key_i    (part_key),
    .delta_i       (delta),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .slot_i        (slot),
    .count_now_i   (count_now),
    .entries_used_i(entries_used),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  // The result side stalls at random, redrawn on every falling edge so that
  // stalls land on every cycle of the block's scan, not only on the result.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offers one item, with a random run of idle cycles before it, and returns
  // on the falling edge after the item was taken. Valid stays high when the
  // next item follows at once, so it is never dropped and raised in one step.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [DELTA_W-1:0] amt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    part_key <= key;
    delta    <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Watchdog: ends the run when neither channel moves an item for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
        quiet_cycles++;
      else
        quiet_cycles = 0;
    end
    $display("[%0t] no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("keyed_count_table verification failed");
    $finish;
  end

  initial begin
    int unsigned      directed_items;
    int unsigned      span;
    int unsigned      pick;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] key;
    logic [DELTA_W-1:0] amt;

    for (int i = 0; i < int'(POOL_KEYS); i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, run under the first idle mix. It starts on an empty table
    // and walks through the corner cases one by one.
    send_item(ACT_LOOKUP, 32'h0000_0000, 16'h0000);  // lookup on an empty table
    send_item(ACT_SUB,    32'hFFFF_FFFF, 16'h0005);  // subtract on an absent key
    send_item(ACT_ADD,    32'h0000_0000, 16'h0000);  // insert with a zero count
    send_item(ACT_ADD,    32'h0000_0000, 16'h0000);  // zero plus zero deletes it
    send_item(ACT_ADD,    32'hFFFF_FFFF, 16'hFFFF);  // all-ones key and amount
    send_item(ACT_ADD,    32'hAAAA_AAAA, 16'h0001);
    send_item(ACT_ADD,    32'h5555_5555, 16'h0002);
    send_item(ACT_ADD,    32'hFFFF_FFFF, 16'hFFFF);  // update an existing count
    send_item(ACT_LOOKUP, 32'h5555_5555, 16'h0000);
    send_item(ACT_SPARE,  32'hAAAA_AAAA, 16'hFFFF);  // unused code acts as lookup
    send_item(ACT_SUB,    32'hAAAA_AAAA, 16'h0001);  // exactly zero: delete, shift
    send_item(ACT_LOOKUP, 32'h5555_5555, 16'h0000);  // now one slot lower
    send_item(ACT_SUB,    32'h5555_5555, 16'h0000);  // subtracting zero
    send_item(ACT_SUB,    32'h5555_5555, 16'h0064);  // going below zero deletes
    send_item(ACT_SUB,    32'hFFFF_FFFF, 16'h8000);
    send_item(ACT_ADD,    HOT_KEY,       16'hFFFF);
    send_item(ACT_LOOKUP, 32'h0000_0001, 16'h0000);
    send_item(ACT_SPARE,  32'h0000_0001, 16'h0000);
    directed_items = items_sent;

    // Random part in three idle mixes: a slow receiver, a slow sender, and
    // neither idling. The middle phase draws from a few keys only, so that
    // most requests hit entries that are present.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 34 : 0;
      span          = (phase == 1) ? 16 : POOL_KEYS;
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          // Mostly large adds on one key, to reach saturation.
          key = HOT_KEY;
          act = ($urandom_range(0, 9) == 0) ? ACT_LOOKUP : ACT_ADD;
          amt = 16'hFFFF;
        end else if (pick < 25) begin
          // Fresh keys: mostly misses, now and then a lasting insert.
          key  = $urandom;
          amt  = DELTA_W'($urandom_range(0, 65535));
          pick = $urandom_range(0, 99);
          act  = (pick < 20) ? ACT_ADD : (pick < 60) ? ACT_SUB :
                 (pick < 90) ? ACT_LOOKUP : ACT_SPARE;
        end else begin
          key  = key_pool[$urandom_range(0, span - 1)];
          pick = $urandom_range(0, 99);
          act  = (pick < 40) ? ACT_ADD : (pick < 80) ? ACT_SUB :
                 (pick < 95) ? ACT_LOOKUP : ACT_SPARE;
          // Zero, full scale and tiny amounts make exact-zero deletes and
          // zero-count entries common.
          pick = $urandom_range(0, 99);
          if (pick < 15)      amt = '0;
          else if (pick < 30) amt = '1;
          else if (pick < 65) amt = DELTA_W'($urandom_range(0, 7));
          else                amt = DELTA_W'($urandom_range(0, 65535));
        end
        send_item(act, key, amt);
      end
    end
    in_valid <= 1'b0;

    // Wait for every result, then keep watching for strays.
    while (outstanding != 0) @(negedge clk);
    repeat (2 * (TABLE_ENTRIES + 2)) @(negedge clk);

    $display("Sent %0d requests: %0d directed corner cases, the rest random over",
             items_sent, directed_items);
    $display("three sender/receiver idle mixes; %0d results compared, %0d mismatches.",
             compared, mismatches);
    if (mismatches == 0) begin
      $display("keyed_count_table verification clean");
    end else begin
      $display("keyed_count_table verification failed");
    end
    $finish;
  end

endmodule
